>>> rtl/spx_pkg.sv
// Shared types and constants of the servo pulse sequencer.
// Holds op codes, register indexes, reset values, the config struct and the width clamp.
// No dependencies.
package spx_pkg;

    // Input op codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_COUNT = 2'd2;

    // Register indexes on the APB port (byte address = 4 * index)
    localparam logic [1:0] REG_FRAME = 2'd0;
    localparam logic [1:0] REG_MIN   = 2'd1;
    localparam logic [1:0] REG_MAX   = 2'd2;

    localparam int APB_AW = 4;

    // Register reset values
    localparam logic [15:0] FRAME_RST = 16'd20000;
    localparam logic [15:0] MIN_RST   = 16'd500;
    localparam logic [15:0] MAX_RST   = 16'd2500;

    typedef struct packed {
        logic [15:0] frame_period_us;
        logic [15:0] min_pulse_us;
        logic [15:0] max_pulse_us;
    } spx_cfg_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SWEEP,
        ST_APPLY
    } seq_state_t;

    // Raise a request below min to min, else lower one above max to max
    function automatic logic [15:0] clamp_width(input logic [15:0] req, input spx_cfg_t regs);
        logic [15:0] w;
        if (req < regs.min_pulse_us) begin
            w = regs.min_pulse_us;
        end else if (req > regs.max_pulse_us) begin
            w = regs.max_pulse_us;
        end else begin
            w = req;
        end
        return w;
    endfunction

endpackage

>>> rtl/spx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
// No dependencies.
module spx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/spx_cfg.sv
// APB register file of the servo pulse sequencer: frame period and pulse limits.
// Depends on spx_pkg for register indexes, reset values and the config struct.
module spx_cfg
    import spx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output spx_cfg_t          regs
);

    spx_cfg_t regs_reg;
    logic     wr_fire;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;
    assign regs    = regs_reg;

    // Write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.frame_period_us <= FRAME_RST;
            regs_reg.min_pulse_us    <= MIN_RST;
            regs_reg.max_pulse_us    <= MAX_RST;
        end else if (wr_fire) begin
            unique case (paddr[3:2])
                REG_FRAME: regs_reg.frame_period_us <= pwdata[15:0];
                REG_MIN:   regs_reg.min_pulse_us    <= pwdata[15:0];
                REG_MAX:   regs_reg.max_pulse_us    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME: prdata = {16'd0, regs_reg.frame_period_us};
            REG_MIN:   prdata = {16'd0, regs_reg.min_pulse_us};
            REG_MAX:   prdata = {16'd0, regs_reg.max_pulse_us};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/spx_slot_store.sv
// Slot store: pin masks and pulse widths in RAM copies, one copy per read port.
// Valid bits make unwritten slots read as zero; same-cycle writes are forwarded.
// Depends on spx_ram.
module spx_slot_store #(
    parameter int SLOTS    = 8,
    parameter int PIN_BITS = 24,
    localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    // write port
    input  logic                wr_en,
    input  logic [SAW-1:0]      wr_addr,
    input  logic [PIN_BITS-1:0] wr_mask,
    input  logic [15:0]         wr_width,
    // query port: width of the slot named by an item
    input  logic [SAW-1:0]      q_addr,
    output logic [15:0]         q_width,
    // current port: mask of the pulsing slot or the sweep entry
    input  logic [SAW-1:0]      c_addr,
    output logic [PIN_BITS-1:0] c_mask,
    // next port: mask and width of the slot raised next
    input  logic [SAW-1:0]      n_addr,
    output logic [PIN_BITS-1:0] n_mask,
    output logic [15:0]         n_width
);

    logic [SLOTS-1:0]    valid_reg;
    logic [PIN_BITS-1:0] wr_mask_reg;
    logic [15:0]         wr_width_reg;
    logic                q_hit_reg, c_hit_reg, n_hit_reg;
    logic                q_vld_reg, c_vld_reg, n_vld_reg;
    logic                q_hit, c_hit, n_hit;
    logic                q_live, c_live, n_live;
    logic [15:0]         q_ram_width, n_ram_width;
    logic [PIN_BITS-1:0] c_ram_mask, n_ram_mask;

    spx_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_width_q (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(wr_width),
        .raddr(q_addr), .rdata(q_ram_width)
    );

    spx_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_width_n (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(wr_width),
        .raddr(n_addr), .rdata(n_ram_width)
    );

    spx_ram #(.WIDTH(PIN_BITS), .DEPTH(SLOTS)) u_mask_c (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(wr_mask),
        .raddr(c_addr), .rdata(c_ram_mask)
    );

    spx_ram #(.WIDTH(PIN_BITS), .DEPTH(SLOTS)) u_mask_n (
        .aclk(aclk), .we(wr_en), .waddr(wr_addr), .wdata(wr_mask),
        .raddr(n_addr), .rdata(n_ram_mask)
    );

    // Detect reads that collide with this cycle's write
    assign q_hit = wr_en && (wr_addr == q_addr);
    assign c_hit = wr_en && (wr_addr == c_addr);
    assign n_hit = wr_en && (wr_addr == n_addr);

    // An entry is live once written
    assign q_live = q_hit || ((32'(q_addr) < 32'(SLOTS)) && valid_reg[q_addr]);
    assign c_live = c_hit || ((32'(c_addr) < 32'(SLOTS)) && valid_reg[c_addr]);
    assign n_live = n_hit || ((32'(n_addr) < 32'(SLOTS)) && valid_reg[n_addr]);

    // Track written entries and register read qualifiers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            q_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
            q_hit_reg <= 1'b0;
            c_hit_reg <= 1'b0;
            n_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            q_vld_reg <= q_live;
            c_vld_reg <= c_live;
            n_vld_reg <= n_live;
            q_hit_reg <= q_hit;
            c_hit_reg <= c_hit;
            n_hit_reg <= n_hit;
        end
    end

    // Hold the write data for forwarding
    always_ff @(posedge aclk) begin
        wr_mask_reg  <= wr_mask;
        wr_width_reg <= wr_width;
    end

    // Select forwarded, stored or zero data
    assign q_width = !q_vld_reg ? 16'd0 : (q_hit_reg ? wr_width_reg : q_ram_width);
    assign c_mask  = !c_vld_reg ? '0 : (c_hit_reg ? wr_mask_reg : c_ram_mask);
    assign n_mask  = !n_vld_reg ? '0 : (n_hit_reg ? wr_mask_reg : n_ram_mask);
    assign n_width = !n_vld_reg ? 16'd0 : (n_hit_reg ? wr_width_reg : n_ram_width);

endmodule

>>> rtl/servo_pulse_sequencer.sv
// Servo pulse sequencer top level: APB registers, slot store and the slot sequencer.
// Depends on spx_pkg, spx_cfg, spx_slot_store and spx_ram.
//
// The block drives servo pins one slot after another. Each input beat is a microsecond
// tick, a slot write (pin mask and a pulse width clamped to the min/max registers) or a new
// active slot count; every beat returns one result beat with the pin levels, the pulsing slot,
// a frame-gap flag and the stored width of the named slot. Slot masks and widths live in RAM
// with registered read data: the slot named by a beat is read while the beat is accepted,
// and the masks and width of the current and next slot are fetched ahead from the state the
// previous beat leaves, with write forwarding. An accepted beat waits in the execute stage
// register and its result is registered in the result register; the block sustains one beat
// per clock while results are taken. The one exception is changing a nonzero count to zero:
// the pins of every active slot are lowered by a pass through the mask RAM, one slot per
// cycle; that beat executes only after the sweep, and input is held off until it executes.
// No clearing pass follows reset: per-slot valid bits make unwritten slots read as zero.
module servo_pulse_sequencer
    import spx_pkg::*;
#(
    parameter int SLOTS    = 8,
    parameter int PIN_BITS = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input beats
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    input  logic [2:0]        s_slot,
    input  logic [23:0]       s_pin_mask,
    input  logic [15:0]       s_pulse_us,
    input  logic [3:0]        s_count,
    // result beats
    output logic              m_valid,
    input  logic              m_ready,
    output logic [23:0]       m_pins,
    output logic [3:0]        m_current_slot,
    output logic              m_in_gap,
    output logic [15:0]       m_slot_pulse_us
);

    localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    // Slot that follows idx at a slot change; zero restarts the frame
    function automatic logic [CW-1:0] following_slot(input logic [CW-1:0] idx,
                                                     input logic [CW-1:0] act,
                                                     input logic [15:0]   sum,
                                                     input logic [15:0]   frame);
        logic [CW-1:0] nxt;
        if (idx >= act) begin
            nxt = '0;
        end else begin
            nxt = idx + 1'b1;
            if (nxt >= act && sum >= frame) begin
                nxt = '0;
            end
        end
        return nxt;
    endfunction

    spx_cfg_t regs;

    // Execute stage register
    logic                p_valid_reg;
    logic [1:0]          p_op_reg;
    logic [2:0]          p_slot_reg;
    logic [PIN_BITS-1:0] p_mask_reg;
    logic [15:0]         p_pulse_reg;
    logic [3:0]          p_count_reg;

    // Sequencer state
    seq_state_t          state_reg, state_next;
    logic [CW-1:0]       active_count_reg, active_count_next;
    logic [CW-1:0]       slot_index_reg, slot_index_next;
    logic [15:0]         ticks_reg, ticks_next;
    logic [15:0]         width_sum_reg, width_sum_next;
    logic [PIN_BITS-1:0] pins_reg, pins_next;
    logic [CW-1:0]       sweep_idx_reg, sweep_idx_next;

    // Result register
    logic                m_valid_reg;
    logic [23:0]         m_pins_reg;
    logic [3:0]          m_slot_reg;
    logic                m_gap_reg;
    logic [15:0]         m_pulse_reg;

    // Control and datapath
    logic                p_load, exec_fire, sweep_on, out_free;
    logic                p_in_range, p_stop;
    logic [CW-1:0]       cnt_sat, ev_index;
    logic [15:0]         width_new;
    logic [PIN_BITS-1:0] lower_mask;
    logic                wr_en;
    logic [SAW-1:0]      q_addr, c_addr, n_addr;
    logic [15:0]         q_width, n_width;
    logic [PIN_BITS-1:0] c_mask, n_mask;

    spx_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready), .regs(regs)
    );

    spx_slot_store #(.SLOTS(SLOTS), .PIN_BITS(PIN_BITS)) u_store (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(wr_en), .wr_addr(SAW'(p_slot_reg)), .wr_mask(p_mask_reg), .wr_width(width_new),
        .q_addr(q_addr), .q_width(q_width),
        .c_addr(c_addr), .c_mask(c_mask),
        .n_addr(n_addr), .n_mask(n_mask), .n_width(n_width)
    );

    // Decode the beat in the execute stage
    assign out_free   = !m_valid_reg || m_ready;
    assign p_in_range = 32'(p_slot_reg) < 32'(SLOTS);
    assign cnt_sat    = (32'(p_count_reg) > 32'(SLOTS)) ? SLOTS_C : CW'(p_count_reg);
    assign p_stop     = (p_op_reg == OP_COUNT) && (cnt_sat == '0) && (active_count_reg != '0);
    assign width_new  = clamp_width(p_pulse_reg, regs);
    assign ev_index   = following_slot(slot_index_reg, active_count_reg, width_sum_reg,
                                       regs.frame_period_us);
    assign lower_mask = (slot_index_reg < active_count_reg) ? c_mask : '0;

    // Handshake
    assign s_ready = !p_valid_reg || exec_fire;
    assign p_load  = s_valid && s_ready;

    // FSM next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (p_valid_reg && p_stop) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sweep_idx_reg == active_count_reg - 1'b1) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // FSM outputs
    always_comb begin
        exec_fire = 1'b0;
        sweep_on  = 1'b0;
        unique case (state_reg)
            ST_RUN:   exec_fire = p_valid_reg && !p_stop && out_free;
            ST_SWEEP: sweep_on  = 1'b1;
            ST_APPLY: exec_fire = out_free;
            default: begin
            end
        endcase
    end

    assign sweep_idx_next = (state_reg == ST_SWEEP) ? sweep_idx_reg + 1'b1 : '0;

    // Execute the beat and compute the next sequencer state
    always_comb begin
        wr_en             = 1'b0;
        active_count_next = active_count_reg;
        slot_index_next   = slot_index_reg;
        ticks_next        = ticks_reg;
        width_sum_next    = width_sum_reg;
        pins_next         = pins_reg;
        // lower one active slot per cycle during the stop pass
        if (sweep_on) begin
            pins_next = pins_reg & ~c_mask;
        end
        if (exec_fire) begin
            case (p_op_reg)
                OP_TICK: begin
                    if (active_count_reg != '0) begin
                        if (ticks_reg > 16'd1) begin
                            ticks_next = ticks_reg - 16'd1;
                        end else begin
                            slot_index_next = ev_index;
                            if (ev_index < active_count_reg) begin
                                ticks_next = n_width;
                                pins_next  = (pins_reg & ~lower_mask) | n_mask;
                            end else begin
                                ticks_next = regs.frame_period_us - width_sum_reg;
                                pins_next  = pins_reg & ~lower_mask;
                            end
                        end
                    end
                end
                OP_WRITE: begin
                    if (p_in_range) begin
                        wr_en          = 1'b1;
                        width_sum_next = width_sum_reg - q_width + width_new;
                    end
                end
                OP_COUNT: begin
                    if (cnt_sat == '0 && active_count_reg != '0) begin
                        // pins were already lowered by the stop pass
                        active_count_next = '0;
                        slot_index_next   = '0;
                        ticks_next        = 16'd0;
                    end else if (active_count_reg == '0 && cnt_sat != '0) begin
                        active_count_next = cnt_sat;
                        slot_index_next   = '0;
                        ticks_next        = n_width;
                        pins_next         = pins_reg | n_mask;
                    end else begin
                        active_count_next = cnt_sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Read addresses: the beat's slot, and a look-ahead from the next state
    assign q_addr = p_load ? SAW'(s_slot) : SAW'(p_slot_reg);
    assign c_addr = (state_next == ST_SWEEP) ? SAW'(sweep_idx_next) : SAW'(slot_index_next);
    assign n_addr = SAW'(following_slot(slot_index_next, active_count_next, width_sum_next,
                                        regs.frame_period_us));

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg      <= 1'b0;
            state_reg        <= ST_RUN;
            active_count_reg <= '0;
            slot_index_reg   <= '0;
            ticks_reg        <= 16'd0;
            width_sum_reg    <= 16'd0;
            pins_reg         <= '0;
            sweep_idx_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (p_load) begin
                p_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                p_valid_reg <= 1'b0;
            end
            state_reg        <= state_next;
            active_count_reg <= active_count_next;
            slot_index_reg   <= slot_index_next;
            ticks_reg        <= ticks_next;
            width_sum_reg    <= width_sum_next;
            pins_reg         <= pins_next;
            sweep_idx_reg    <= sweep_idx_next;
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (p_load) begin
            p_op_reg    <= s_op;
            p_slot_reg  <= s_slot;
            p_mask_reg  <= PIN_BITS'(s_pin_mask);
            p_pulse_reg <= s_pulse_us;
            p_count_reg <= s_count;
        end
        if (exec_fire) begin
            m_pins_reg  <= 24'(pins_next);
            m_slot_reg  <= 4'(slot_index_next);
            m_gap_reg   <= (active_count_next != '0) && (slot_index_next >= active_count_next);
            m_pulse_reg <= !p_in_range ? 16'd0 :
                           ((p_op_reg == OP_WRITE) ? width_new : q_width);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pins          = m_pins_reg;
    assign m_current_slot  = m_slot_reg;
    assign m_in_gap        = m_gap_reg;
    assign m_slot_pulse_us = m_pulse_reg;

    // A stopped sequencer sits at slot zero with nothing counting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (active_count_reg == '0) |-> (slot_index_reg == '0 && ticks_reg == 16'd0))
        else $error("stopped sequencer holds a slot or tick count");

    // The stop pass holds a beat and takes no new one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (p_valid_reg && !s_ready && !exec_fire))
        else $error("beat moved during the stop pass");

    // Active count never exceeds the slot count
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_count_reg <= SLOTS_C)
        else $error("active count above slot count");

    // A stop beat always passes through the sweep before it executes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && p_valid_reg && p_stop) |=> (state_reg == ST_SWEEP))
        else $error("stop beat skipped the sweep");

endmodule
